[sv/adam_pkg.sv]
// Shared types, constants and helpers for the Adam parameter update block.
`timescale 1ns / 1ps
package adam_pkg;

  // Data format: signed Q8.24 in 32 bits, second moment nonnegative in 31 bits
  localparam int DATA_W     = 32;
  localparam int VAR_W      = 31;
  localparam int REG_W      = 24;
  localparam int GSC_W      = 25;
  localparam int POW_W      = 25;
  localparam int REG_FRAC   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // Iteration steps folded into each stage of the divider and root pipes
  localparam int STEPS_PER_STAGE = 4;

  localparam logic [POW_W-1:0] POW_ONE = POW_W'(1) << REG_FRAC;

  localparam logic [REG_W-1:0] LR_RST    = REG_W'(16777);
  localparam logic [REG_W-1:0] BETA1_RST = REG_W'(15099494);
  localparam logic [REG_W-1:0] BETA2_RST = REG_W'(16760439);
  localparam logic [REG_W-1:0] EPS_RST   = REG_W'(1);
  localparam logic [GSC_W-1:0] GSC_RST   = GSC_W'(16777216);

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LR     = 3'd0,
    CFG_BETA1  = 3'd1,
    CFG_BETA2  = 3'd2,
    CFG_EPS    = 3'd3,
    CFG_GSCALE = 3'd4
  } cfg_idx_e;

  // Accepted request with its bias corrections
  typedef struct packed {
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] grad;
    logic signed [DATA_W-1:0] mom1;
    logic [VAR_W-1:0]         mom2;
    logic [POW_W-1:0]         bc1;
    logic [POW_W-1:0]         bc2;
  } front_t;

  // Request after the moment update
  typedef struct packed {
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] mom1;
    logic [VAR_W-1:0]         mom2;
    logic [POW_W-1:0]         bc1;
    logic [POW_W-1:0]         bc2;
  } moment_t;

  // Clamp a wide signed value to the data range
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [64:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 65'(DATA_MAX)) begin
      r = DATA_MAX;
    end else if (x < 65'(DATA_MIN)) begin
      r = DATA_MIN;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/adam_div_pipe.sv]
// Pipelined restoring divider with overflow flag and sideband pass-through.
`timescale 1ns / 1ps
module adam_div_pipe #(
  parameter int NW  = 56,
  parameter int DW  = 25,
  parameter int QW  = 32,
  parameter int BPS = 4,
  parameter int SW  = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o,
  output logic [SW-1:0] side_o
);

  localparam int NSTG = (QW + BPS - 1) / BPS;

  logic [DW-1:0] rem_q  [NSTG+1];
  logic [QW-1:0] nlo_q  [NSTG+1];
  logic [QW-1:0] quo_q  [NSTG+1];
  logic [DW-1:0] den_q  [NSTG+1];
  logic          ovf_q  [NSTG+1];
  logic          vld_q  [NSTG+1];
  logic [SW-1:0] side_q [NSTG+1];

  logic [DW-1:0] hi_d;
  logic          ovf_d;

  // Quotient fits in QW bits only while the upper numerator stays below the divisor
  assign hi_d  = DW'(num_i >> QW);
  assign ovf_d = (hi_d >= den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= ovf_d ? '0 : hi_d;
      nlo_q[0]  <= num_i[QW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      ovf_q[0]  <= ovf_d;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s <= NSTG; s++) begin : g_stg
    logic [DW-1:0] rem_d;
    logic [QW-1:0] nlo_d;
    logic [QW-1:0] quo_d;

    // Shift in one numerator bit per step, subtract when it fits
    always_comb begin
      logic [DW:0] t;
      rem_d = rem_q[s-1];
      nlo_d = nlo_q[s-1];
      quo_d = quo_q[s-1];
      for (int j = 0; j < BPS; j++) begin
        if ((s - 1) * BPS + j < QW) begin
          t     = {rem_d, nlo_d[QW-1]};
          nlo_d = {nlo_d[QW-2:0], 1'b0};
          if (t >= {1'b0, den_q[s-1]}) begin
            t     = t - {1'b0, den_q[s-1]};
            quo_d = {quo_d[QW-2:0], 1'b1};
          end else begin
            quo_d = {quo_d[QW-2:0], 1'b0};
          end
          rem_d = t[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        nlo_q[s]  <= nlo_d;
        quo_q[s]  <= quo_d;
        den_q[s]  <= den_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[NSTG];
  assign quo_o   = quo_q[NSTG];
  assign ovf_o   = ovf_q[NSTG];
  assign side_o  = side_q[NSTG];

endmodule

[sv/adam_sqrt_pipe.sv]
// Pipelined digit-by-digit integer square root with sideband pass-through.
`timescale 1ns / 1ps
module adam_sqrt_pipe #(
  parameter int XW  = 56,
  parameter int BPS = 4,
  parameter int SW  = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [XW-1:0]   x_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [XW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);

  localparam int RW   = XW / 2;
  localparam int NSTG = (RW + BPS - 1) / BPS;

  logic [RW+1:0] rem_q  [NSTG+1];
  logic [RW-1:0] root_q [NSTG+1];
  logic [XW-1:0] xs_q   [NSTG+1];
  logic          vld_q  [NSTG+1];
  logic [SW-1:0] side_q [NSTG+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      xs_q[0]   <= x_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s <= NSTG; s++) begin : g_stg
    logic [RW+1:0] rem_d;
    logic [RW-1:0] root_d;
    logic [XW-1:0] xs_d;

    // Bring down two bits per step and try the next root bit
    always_comb begin
      logic [RW+3:0] t;
      logic [RW+3:0] trial;
      rem_d  = rem_q[s-1];
      root_d = root_q[s-1];
      xs_d   = xs_q[s-1];
      for (int j = 0; j < BPS; j++) begin
        if ((s - 1) * BPS + j < RW) begin
          t     = {rem_d, xs_d[XW-1:XW-2]};
          xs_d  = {xs_d[XW-3:0], 2'b00};
          trial = {2'b00, root_d, 2'b01};
          if (t >= trial) begin
            t      = t - trial;
            root_d = {root_d[RW-2:0], 1'b1};
          end else begin
            root_d = {root_d[RW-2:0], 1'b0};
          end
          rem_d = t[RW+1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        xs_q[s]   <= xs_d;
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[NSTG];
  assign root_o  = root_q[NSTG];
  assign side_o  = side_q[NSTG];

endmodule

[sv/adam_moment_pipe.sv]
// Six-stage gradient scaling and moment update pipeline.
`timescale 1ns / 1ps
module adam_moment_pipe (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  adam_pkg::front_t                     front_i,
  input  logic [adam_pkg::REG_W-1:0]           beta1_i,
  input  logic [adam_pkg::REG_W-1:0]           beta2_i,
  input  logic [adam_pkg::GSC_W-1:0]           gscale_i,
  output logic                                 valid_o,
  output adam_pkg::moment_t                    mom_o
);
  import adam_pkg::*;

  localparam int NST = 6;

  front_t frt_q [NST];
  logic   vld_q [NST];

  logic signed [57:0]       prod_g_q;
  logic signed [DATA_W-1:0] g_q;
  logic signed [56:0]       pa_q;
  logic signed [57:0]       pb_q;
  logic signed [63:0]       gg_q;
  logic signed [DATA_W-1:0] m1_s4_q, m1_s5_q, m1_s6_q;
  logic [38:0]              g2_q;
  logic [54:0]              qa_q;
  logic [63:0]              qb_q;
  logic [VAR_W-1:0]         v1_q;

  logic signed [57:0]       g_sum;
  logic signed [DATA_W-1:0] g_d;
  logic [REG_W:0]           omb1, omb2;
  logic signed [58:0]       m_sum;
  logic signed [DATA_W-1:0] m1_d;
  logic [63:0]              gg_sum;
  logic [64:0]              v_sum;
  logic [VAR_W-1:0]         v1_d;

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Round and clamp the scaled gradient
  assign g_sum = prod_g_q + 58'sd8388608;
  assign g_d   = sat_data(65'($signed(g_sum[57:REG_FRAC])));

  assign omb1 = (REG_W+1)'(POW_ONE) - {1'b0, beta1_i};
  assign omb2 = (REG_W+1)'(POW_ONE) - {1'b0, beta2_i};

  // First moment blend, and squared gradient back to data scale
  assign m_sum  = 59'(pa_q) + 59'(pb_q) + 59'sd8388608;
  assign m1_d   = sat_data(65'($signed(m_sum[58:REG_FRAC])));
  assign gg_sum = $unsigned(gg_q) + 64'd8388608;

  // Second moment blend, clamped to the upper bound
  assign v_sum = 65'(qa_q) + 65'(qb_q) + 65'd8388608;
  assign v1_d  = (v_sum[64:REG_FRAC] > 41'(VAR_MAX)) ? VAR_MAX : v_sum[REG_FRAC+VAR_W-1:REG_FRAC];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      frt_q[0] <= front_i;
      for (int i = 1; i < NST; i++) frt_q[i] <= frt_q[i-1];
      // stage 1: gradient times batch scale
      prod_g_q <= front_i.grad * $signed({1'b0, gscale_i});
      // stage 2
      g_q <= g_d;
      // stage 3: blend products and gradient square
      pa_q <= $signed({1'b0, beta1_i}) * frt_q[1].mom1;
      pb_q <= $signed({1'b0, omb1}) * g_q;
      gg_q <= g_q * g_q;
      // stage 4
      m1_s4_q <= m1_d;
      g2_q    <= gg_sum[REG_FRAC+38:REG_FRAC];
      // stage 5
      qa_q    <= beta2_i * frt_q[3].mom2;
      qb_q    <= omb2 * g2_q;
      m1_s5_q <= m1_s4_q;
      // stage 6
      v1_q    <= v1_d;
      m1_s6_q <= m1_s5_q;
    end
  end

  assign valid_o       = vld_q[NST-1];
  assign mom_o.weight  = frt_q[NST-1].weight;
  assign mom_o.mom1    = m1_s6_q;
  assign mom_o.mom2    = v1_q;
  assign mom_o.bc1     = frt_q[NST-1].bc1;
  assign mom_o.bc2     = frt_q[NST-1].bc2;

endmodule

[sv/adam_parameter_update_top.sv]
// Top level of the pipelined Adam parameter update.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_stall_o | begin_step, weight, gradient, moments
//   out     | output    | out_valid_o/out_stall_i | weight, first and second moment
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One request enters per cycle and one result leaves per cycle unless a held result
// is stalled on the output. A request passes through the moment pipe, the two
// bias-correction dividers side by side, the root, the step register, the step
// divider and the output register.
// Reset restores the register defaults and both running beta powers to one.
// A stall on the output while a result is held freezes every stage at once; the input stalls with it.
`timescale 1ns / 1ps
module adam_parameter_update_top #(
  parameter int PIPE_STEPS = adam_pkg::STEPS_PER_STAGE
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [adam_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [adam_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               begin_step_i,
  input  logic signed [adam_pkg::DATA_W-1:0] weight_in_i,
  input  logic signed [adam_pkg::DATA_W-1:0] gradient_sum_i,
  input  logic signed [adam_pkg::DATA_W-1:0] first_moment_in_i,
  input  logic [adam_pkg::VAR_W-1:0]         second_moment_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [adam_pkg::DATA_W-1:0] weight_out_o,
  output logic signed [adam_pkg::DATA_W-1:0] first_moment_out_o,
  output logic [adam_pkg::VAR_W-1:0]         second_moment_out_o
);
  import adam_pkg::*;

  localparam int MW  = 2 * DATA_W + VAR_W;   // weight, first and second moment
  localparam int DNW = 56;
  localparam int RTW = 28;

  // Configuration registers and running powers
  logic [REG_W-1:0] lr_q, beta1_q, beta2_q, eps_q;
  logic [GSC_W-1:0] gsc_q;
  logic [POW_W-1:0] pow1_q, pow2_q;

  logic en, accept;
  logic out_valid_q;
  logic signed [DATA_W-1:0] w_out_q, m_out_q;
  logic [VAR_W-1:0] v_out_q;

  // Advance the whole pipe unless a finished result is held
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q    <= LR_RST;
      beta1_q <= BETA1_RST;
      beta2_q <= BETA2_RST;
      eps_q   <= EPS_RST;
      gsc_q   <= GSC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LR:     lr_q    <= cfg_data_i[REG_W-1:0];
        CFG_BETA1:  beta1_q <= cfg_data_i[REG_W-1:0];
        CFG_BETA2:  beta2_q <= cfg_data_i[REG_W-1:0];
        CFG_EPS:    eps_q   <= cfg_data_i[REG_W-1:0];
        CFG_GSCALE: gsc_q   <= cfg_data_i[GSC_W-1:0];
        default:    ;
      endcase
    end
  end

  // Advance the running powers on the first element of a step
  logic [POW_W+REG_W-1:0] pn1_prod, pn2_prod;
  logic [POW_W-1:0] pow1_d, pow2_d;
  logic [POW_W:0]   bc1_raw, bc2_raw;
  logic [POW_W-1:0] bc1_d, bc2_d;

  assign pn1_prod = pow1_q * beta1_q;
  assign pn2_prod = pow2_q * beta2_q;
  assign pow1_d   = begin_step_i ? pn1_prod[POW_W+REG_W-1:REG_FRAC] : pow1_q;
  assign pow2_d   = begin_step_i ? pn2_prod[POW_W+REG_W-1:REG_FRAC] : pow2_q;
  assign bc1_raw  = {1'b0, POW_ONE} - {1'b0, pow1_d};
  assign bc2_raw  = {1'b0, POW_ONE} - {1'b0, pow2_d};
  // No correction yet: use one LSB
  assign bc1_d = (bc1_raw[POW_W] || bc1_raw == '0) ? POW_W'(1) : bc1_raw[POW_W-1:0];
  assign bc2_d = (bc2_raw[POW_W] || bc2_raw == '0) ? POW_W'(1) : bc2_raw[POW_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow1_q <= POW_ONE;
      pow2_q <= POW_ONE;
    end else if (accept) begin
      pow1_q <= pow1_d;
      pow2_q <= pow2_d;
    end
  end

  front_t front_d;
  assign front_d.weight = weight_in_i;
  assign front_d.grad   = gradient_sum_i;
  assign front_d.mom1   = first_moment_in_i;
  assign front_d.mom2   = second_moment_in_i;
  assign front_d.bc1    = bc1_d;
  assign front_d.bc2    = bc2_d;

  logic    mom_valid;
  moment_t mom;

  adam_moment_pipe u_moment (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (accept),
    .front_i  (front_d),
    .beta1_i  (beta1_q),
    .beta2_i  (beta2_q),
    .gscale_i (gsc_q),
    .valid_o  (mom_valid),
    .mom_o    (mom)
  );

  // Bias correction: magnitude times one, plus half divisor for rounding
  logic [DATA_W-1:0] m1_mag;
  logic [DNW-1:0]    mh_num, vh_num;

  assign m1_mag = mom.mom1[DATA_W-1] ? (~$unsigned(mom.mom1) + 1'b1) : $unsigned(mom.mom1);
  assign mh_num = {m1_mag, {REG_FRAC{1'b0}}} + DNW'(mom.bc1 >> 1);
  assign vh_num = DNW'({mom.mom2, {REG_FRAC{1'b0}}}) + DNW'(mom.bc2 >> 1);

  logic              mh_valid, vh_valid, mh_ovf, vh_ovf;
  logic [DATA_W-1:0] mh_quo, vh_quo;
  logic [2*DATA_W-1:0] mh_side;
  logic [VAR_W-1:0]  vh_side;

  adam_div_pipe #(
    .NW (DNW), .DW (POW_W), .QW (DATA_W), .BPS (PIPE_STEPS), .SW (2 * DATA_W)
  ) u_div_m (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mom_valid),
    .num_i   (mh_num),
    .den_i   (mom.bc1),
    .side_i  ({mom.weight, mom.mom1}),
    .valid_o (mh_valid),
    .quo_o   (mh_quo),
    .ovf_o   (mh_ovf),
    .side_o  (mh_side)
  );

  adam_div_pipe #(
    .NW (DNW), .DW (POW_W), .QW (DATA_W), .BPS (PIPE_STEPS), .SW (VAR_W)
  ) u_div_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mom_valid),
    .num_i   (vh_num),
    .den_i   (mom.bc2),
    .side_i  (mom.mom2),
    .valid_o (vh_valid),
    .quo_o   (vh_quo),
    .ovf_o   (vh_ovf),
    .side_o  (vh_side)
  );

  // Clamp corrected moments; a negative one may reach one step further
  logic signed [DATA_W-1:0] cm_w, cm_m1;
  logic [DATA_W-1:0] mh_cap, mh_mag;
  logic [VAR_W-1:0]  vh_val;

  assign cm_w   = mh_side[2*DATA_W-1:DATA_W];
  assign cm_m1  = mh_side[DATA_W-1:0];
  assign mh_cap = cm_m1[DATA_W-1] ? $unsigned(DATA_MIN) : $unsigned(DATA_MAX);
  assign mh_mag = (mh_ovf || mh_quo > mh_cap) ? mh_cap : mh_quo;
  assign vh_val = (vh_ovf || vh_quo > DATA_W'(VAR_MAX)) ? VAR_MAX : vh_quo[VAR_W-1:0];

  logic               rt_valid;
  logic [RTW-1:0]     rt_root;
  logic [MW+DATA_W-1:0] rt_side;

  adam_sqrt_pipe #(
    .XW (DNW), .BPS (PIPE_STEPS), .SW (MW + DATA_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mh_valid && vh_valid),
    .x_i     (DNW'({vh_val, {REG_FRAC{1'b0}}})),
    .side_i  ({cm_w, cm_m1, vh_side, mh_mag}),
    .valid_o (rt_valid),
    .root_o  (rt_root),
    .side_o  (rt_side)
  );

  // Step numerator and denominator
  logic [RTW:0]        den_raw, den_d;
  logic                st_valid_q;
  logic [DNW-1:0]      st_prod_q;
  logic [RTW:0]        st_den_q;
  logic [MW-1:0]       st_side_q;

  assign den_raw = {1'b0, rt_root} + (RTW+1)'(eps_q);
  assign den_d   = (den_raw == '0) ? (RTW+1)'(1) : den_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (en) begin
      st_valid_q <= rt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_prod_q <= DNW'(lr_q) * DNW'(rt_side[DATA_W-1:0]);
      st_den_q  <= den_d;
      st_side_q <= rt_side[MW+DATA_W-1:DATA_W];
    end
  end

  logic              fd_valid, fd_ovf;
  logic [DATA_W:0]   fd_quo;
  logic [MW-1:0]     fd_side;

  adam_div_pipe #(
    .NW (DNW), .DW (RTW + 1), .QW (DATA_W + 1), .BPS (PIPE_STEPS), .SW (MW)
  ) u_div_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (st_valid_q),
    .num_i   (st_prod_q + DNW'(st_den_q >> 1)),
    .den_i   (st_den_q),
    .side_i  (st_side_q),
    .valid_o (fd_valid),
    .quo_o   (fd_quo),
    .ovf_o   (fd_ovf),
    .side_o  (fd_side)
  );

  // Apply the step to the weight and clamp
  logic signed [DATA_W-1:0] f_w, f_m1;
  logic [VAR_W-1:0]         f_v1;
  logic signed [DATA_W+2:0] f_diff;
  logic signed [DATA_W-1:0] w_new;

  assign f_w  = fd_side[MW-1:DATA_W+VAR_W];
  assign f_m1 = fd_side[DATA_W+VAR_W-1:VAR_W];
  assign f_v1 = fd_side[VAR_W-1:0];
  assign f_diff = f_m1[DATA_W-1] ? ((DATA_W+3)'(f_w) + $signed({2'b00, fd_quo}))
                                 : ((DATA_W+3)'(f_w) - $signed({2'b00, fd_quo}));
  assign w_new = fd_ovf ? (f_m1[DATA_W-1] ? DATA_MAX : DATA_MIN)
                        : sat_data(65'(f_diff));

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_out_q <= w_new;
      m_out_q <= f_m1;
      v_out_q <= f_v1;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign weight_out_o        = w_out_q;
  assign first_moment_out_o  = m_out_q;
  assign second_moment_out_o = v_out_q;

endmodule
